[design/rhsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared constants and types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int CHAN_W  = 8;
	localparam int HUE_W   = 15;
	localparam int LUT_W   = 8;

	// Reciprocal scaling: floor(n / d) = (n * ceil(2^SHIFT / d)) >> SHIFT
	// holds exactly for n below 2^20 and d up to 255.
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	localparam int HNUM_W = 20;	// |diff| * 3840
	localparam int SNUM_W = 16;	// chroma * 255
	localparam int HQ_W   = 12;	// quotient up to 3840

	localparam logic [HUE_W:0] HUE_GREEN_OFS = 16'd7680;
	localparam logic [HUE_W:0] HUE_BLUE_OFS  = 16'd15360;
	localparam logic [HUE_W:0] HUE_FULL      = 16'd23040;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		sector_t sector;
		logic    neg;
		logic    gray;
	} hue_ctl_t;

endpackage
`default_nettype wire

[design/rhsv_rgb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_rgb_if
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface rhsv_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

[design/rhsv_hsv_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_hsv_if
// Valid/ready channel carrying one HSV result per transaction.
// ----------------------------------------------------------------------------
interface rhsv_hsv_if;
	logic        valid;
	logic        ready;
	logic [14:0] hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;
	logic        gray;

	modport source (output valid, output hue, output saturation, output brightness,
		output gray, input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		input gray, output ready);
endinterface
`default_nettype wire

[design/rhsv_recip_lut.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_recip_lut
// Constant table of rounded-up reciprocals ceil(2^RECIP_SHIFT / d), d = 1..255.
// ----------------------------------------------------------------------------
module rhsv_recip_lut
	import rhsv_pkg::*;
(
	input  wire logic [LUT_W-1:0]   idx,
	output      logic [RECIP_W-1:0] recip
);

	localparam int DEPTH = 1 << LUT_W;

	logic [RECIP_W-1:0] tab [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_tab
		localparam longint DIV = (i == 0) ? 1 : i;
		// entry zero only serves gray pixels, whose quotients are dropped
		localparam logic [RECIP_W-1:0] VAL = (i == 0) ? '0 :
			RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV - 1) / DIV);
		assign tab[i] = VAL;
	end

	assign recip = tab[idx];

endmodule
`default_nettype wire

[design/rgb_to_hsv_convert_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each accepted pixel passes through the four registered stages s1 to s4 to hsv_out.
// Throughput: one pixel per cycle unless hsv_out stalls; a ready chain across
// the four valid-tagged stages fills a bubble anywhere on the next cycle.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_core
// Pipelined 8-bit RGB to HSV converter with reciprocal-multiply division.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_core
	import rhsv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	rhsv_rgb_if.sink   pix_in,
	rhsv_hsv_if.source hsv_out
);

	// stage enables
	logic en_s1, en_s2, en_s3, en_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign en_s4 = !vld_s4 || hsv_out.ready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign pix_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= pix_in.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// ---- stage 1: max, min, sector and signed difference
	logic [CHAN_W-1:0] r_in, g_in, b_in, mx_c, mn_c, absd_c;
	logic [CHAN_W:0]   diff_c;
	hue_ctl_t          ctl_c;

	assign r_in = pix_in.red;
	assign g_in = pix_in.green;
	assign b_in = pix_in.blue;

	always_comb begin
		mx_c = r_in;
		mn_c = r_in;
		if (g_in > mx_c) mx_c = g_in;
		if (b_in > mx_c) mx_c = b_in;
		if (g_in < mn_c) mn_c = g_in;
		if (b_in < mn_c) mn_c = b_in;

		// red wins ties, then green
		priority if (r_in == mx_c) begin
			ctl_c.sector = SEC_RED;
			diff_c = {1'b0, g_in} - {1'b0, b_in};
		end else if (g_in == mx_c) begin
			ctl_c.sector = SEC_GREEN;
			diff_c = {1'b0, b_in} - {1'b0, r_in};
		end else begin
			ctl_c.sector = SEC_BLUE;
			diff_c = {1'b0, r_in} - {1'b0, g_in};
		end
		ctl_c.neg  = diff_c[CHAN_W];
		ctl_c.gray = (mx_c == mn_c);
		absd_c = diff_c[CHAN_W] ? CHAN_W'(-diff_c) : diff_c[CHAN_W-1:0];
	end

	logic [CHAN_W-1:0] mx_s1, chroma_s1, absd_s1;
	hue_ctl_t          ctl_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1     <= mx_c;
			chroma_s1 <= mx_c - mn_c;
			absd_s1   <= absd_c;
			ctl_s1    <= ctl_c;
		end
	end

	// ---- stage 2: reciprocal lookup and constant-scaled numerators
	logic [RECIP_W-1:0] rc_c, rm_c;

	rhsv_recip_lut u_recip_chroma (
		.idx   (chroma_s1),
		.recip (rc_c)
	);

	rhsv_recip_lut u_recip_max (
		.idx   (mx_s1),
		.recip (rm_c)
	);

	logic [RECIP_W-1:0] rc_s2, rm_s2;
	logic [HNUM_W-1:0]  hnum_s2;
	logic [SNUM_W-1:0]  snum_s2;
	logic [CHAN_W-1:0]  mx_s2;
	hue_ctl_t           ctl_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rc_s2   <= rc_c;
			rm_s2   <= rm_c;
			// x * 3840 = x * 4096 - x * 256
			hnum_s2 <= (HNUM_W'(absd_s1) << 12) - (HNUM_W'(absd_s1) << 8);
			// x * 255 = x * 256 - x
			snum_s2 <= (SNUM_W'(chroma_s1) << 8) - SNUM_W'(chroma_s1);
			mx_s2   <= mx_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	// ---- stage 3: multiply by reciprocal, keep the integer quotient
	logic [HNUM_W+RECIP_W-1:0] hprod_c;
	logic [SNUM_W+RECIP_W-1:0] sprod_c;

	assign hprod_c = (HNUM_W+RECIP_W)'(hnum_s2) * (HNUM_W+RECIP_W)'(rc_s2);
	assign sprod_c = (SNUM_W+RECIP_W)'(snum_s2) * (SNUM_W+RECIP_W)'(rm_s2);

	logic [HQ_W-1:0]   hq_s3;
	logic [CHAN_W-1:0] sat_s3, mx_s3;
	hue_ctl_t          ctl_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			hq_s3  <= hprod_c[RECIP_SHIFT +: HQ_W];
			sat_s3 <= sprod_c[RECIP_SHIFT +: CHAN_W];
			mx_s3  <= mx_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// ---- stage 4: sector offset, sign, wrap and gray override
	logic [HUE_W:0] ofs_c, hsum_c;
	logic [HUE_W-1:0] hue_c;

	always_comb begin
		unique case (ctl_s3.sector)
			SEC_RED:   ofs_c = '0;
			SEC_GREEN: ofs_c = HUE_GREEN_OFS;
			SEC_BLUE:  ofs_c = HUE_BLUE_OFS;
			default:   ofs_c = '0;
		endcase
		hsum_c = ctl_s3.neg ? ofs_c - (HUE_W+1)'(hq_s3) : ofs_c + (HUE_W+1)'(hq_s3);
		// wrap a negative red-sector hue into range
		if (hsum_c[HUE_W]) hsum_c = hsum_c + HUE_FULL;
		hue_c = ctl_s3.gray ? '0 : hsum_c[HUE_W-1:0];
	end

	logic [HUE_W-1:0]  hue_s4;
	logic [CHAN_W-1:0] sat_s4, mx_s4;
	logic              gray_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			hue_s4  <= hue_c;
			sat_s4  <= ctl_s3.gray ? '0 : sat_s3;
			mx_s4   <= mx_s3;
			gray_s4 <= ctl_s3.gray;
		end
	end

	assign hsv_out.valid      = vld_s4;
	assign hsv_out.hue        = hue_s4;
	assign hsv_out.saturation = sat_s4;
	assign hsv_out.brightness = mx_s4;
	assign hsv_out.gray       = gray_s4;

endmodule
`default_nettype wire
